// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/tfn_pkg.sv -----
// Package with shared types and constants of the triangle face normal block.
`default_nettype none
package tfn_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TRI  = 1'b1;
  localparam int NORM_BITS = 16;
  localparam int ONE_Q14   = 16384;
  // Fixed-point layout of the normalized magnitudes.
  localparam int MAG_BITS  = 20;
  localparam int SUM_BITS  = 42;
  localparam int RAD_BITS  = 62;
  localparam int ROOT_BITS = 31;
  // The rounded dividend mag * 2^24 + root / 2 can reach just above 2^44.
  localparam int DIVD_BITS = 45;
  localparam int QUO_BITS  = 25;

  typedef struct packed {
    logic start;
    logic busy;
  } seq_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/tfn_store.sv -----
// Vertex store: a synchronous simple dual-port memory with a registered read.
`default_nettype none
module tfn_store #(
  parameter int SLOTS = 4096,
  parameter int CB    = 16,
  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire logic [3*CB-1:0] wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output logic      [3*CB-1:0] rdata
);
  logic [3*CB-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tfn_isqrt.sv -----
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module tfn_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tfn_pkg::RAD_BITS-1:0]  radicand,
  output logic                               done,
  output logic      [tfn_pkg::ROOT_BITS-1:0] root
);
  localparam int RB = tfn_pkg::RAD_BITS;
  localparam int QB = tfn_pkg::ROOT_BITS;
  logic [RB-1:0] rem;
  logic [RB-1:0] x;
  logic [5:0]    cnt;
  logic          busy;
  logic [QB+1:0] trial;
  logic [QB+1:0] remw;

  always_comb begin
    remw  = {rem[QB-1:0], x[RB-1 -: 2]};
    trial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(QB);
        rem  <= '0;
        root <= '0;
        x    <= radicand;
      end else if (busy) begin
        x <= {x[RB-3:0], 2'b00};
        if (remw >= trial) begin
          rem  <= RB'(remw - trial);
          root <= {root[QB-2:0], 1'b1};
        end else begin
          rem  <= RB'(remw);
          root <= {root[QB-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tfn_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tfn_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tfn_pkg::DIVD_BITS-1:0] dividend,
  input  wire logic [tfn_pkg::ROOT_BITS-1:0] divisor,
  output logic                               done,
  output logic      [tfn_pkg::QUO_BITS-1:0]  quot
);
  localparam int DB = tfn_pkg::DIVD_BITS;
  localparam int QB = tfn_pkg::QUO_BITS;
  localparam int RB = tfn_pkg::ROOT_BITS;
  logic [DB-1:0] num;
  logic [RB:0]   rem;
  logic [RB:0]   sh;
  logic [5:0]    cnt;
  logic          busy;

  assign sh = {rem[RB-1:0], num[DB-1]};

  // The quotient fits QB bits, so the top DB-QB dividend bits seed the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(QB);
        rem  <= (RB+1)'(dividend[DB-1:QB]);
        num  <= {dividend[QB-1:0], {(DB-QB){1'b0}}};
        quot <= '0;
      end else if (busy) begin
        num <= {num[DB-2:0], 1'b0};
        if (sh >= {1'b0, divisor}) begin
          rem  <= sh - {1'b0, divisor};
          quot <= {quot[QB-2:0], 1'b1};
        end else begin
          rem  <= sh;
          quot <= {quot[QB-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/triangle_face_normal_top.sv -----
// Top level of the triangle face normal block.
//
// Input channel (in_valid/in_stall): an item with opcode load writes one
// vertex position into the store at vertex_slot and produces no result. An
// item with opcode triangle names three corners. The block reads the three
// positions from the store in states S_RDA, S_RDB and S_RDC, forms
// U = B - A and V = C - A, computes N = -(U x V) with one multiplier,
// normalizes the magnitudes with one shift per cycle (up to 19 shifts),
// sums the squares, takes a serial square root, then three serial
// divisions, one per component. Triangles are worked one at a time.
// A degenerate triangle skips the square root and the divisions.
// Output channel (out_valid/out_stall): a result sits in an output register
// until taken; while it waits the block still accepts a load item, and the
// next triangle may run up to the point of delivering its own result.
// A zero cross product gives a zero vector with degenerate set.
// Reset (rst, synchronous) clears the sequencer and out_valid; the vertex
// store is not cleared and reading a never-written slot gives garbage.
`default_nettype none
module triangle_face_normal_top #(
  parameter int VERTEX_SLOTS = 4096,
  parameter int COORD_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [11:0] vertex_slot,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] pos_z,
  input  wire logic [11:0] corner_a,
  input  wire logic [11:0] corner_b,
  input  wire logic [11:0] corner_c,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic             degenerate
);
  localparam int CB = COORD_BITS;
  localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
  localparam int DW = CB + 1;          // difference width
  localparam int PW = 2 * DW;          // product width
  localparam int NW = PW + 1;          // cross component width
  localparam int MB = tfn_pkg::MAG_BITS;

  localparam logic [3:0] S_IDLE = 4'd0, S_RDA = 4'd1, S_RDB = 4'd2, S_RDC = 4'd3,
                         S_WC = 4'd4, S_MUL = 4'd5, S_NORM = 4'd6, S_SQ = 4'd7,
                         S_ROOT = 4'd8, S_DIV = 4'd9, S_DWAIT = 4'd10, S_OUT = 4'd11;

  logic [3:0] state;
  tfn_pkg::seq_ctl_t root_ctl, div_ctl;

  // Corner latches and vertex data.
  logic [11:0] ca, cb_i, cc;
  logic        va, vb, vc;
  logic signed [CB-1:0] ax, ay, az, bx, by, bz;
  logic [3*CB-1:0] rd;

  // Store access.
  logic take, is_load, ld_ok;
  logic [AW-1:0] raddr;
  logic          re;
  logic [3*CB-1:0] wdata;

  assign take    = in_valid && !in_stall;
  assign is_load = (opcode == tfn_pkg::OP_LOAD);
  assign ld_ok   = (32'(vertex_slot) < 32'(VERTEX_SLOTS));
  assign in_stall = !(state == S_IDLE) && !(is_load && state != S_RDA && state != S_RDB
                    && state != S_RDC && state != S_WC);
  // Coordinates wrap to CB bits when narrower than the field.
  assign wdata = {CB'(pos_z), CB'(pos_y), CB'(pos_x)};

  always_comb begin
    re    = 1'b0;
    raddr = AW'(ca);
    case (state)
      S_RDA: begin re = 1'b1; raddr = AW'(ca); end
      S_RDB: begin re = 1'b1; raddr = AW'(cb_i); end
      S_RDC: begin re = 1'b1; raddr = AW'(cc); end
      default: re = 1'b0;
    endcase
  end

  tfn_store #(.SLOTS(VERTEX_SLOTS), .CB(CB)) u_store (
    .clk(clk), .we(take && is_load && ld_ok), .waddr(AW'(vertex_slot)),
    .wdata(wdata), .re(re), .raddr(raddr), .rdata(rd)
  );

  // Differences.
  logic signed [DW-1:0] ux, uy, uz, wx, wy, wz;
  logic signed [CB-1:0] rx, ry, rz;
  assign rx = vc ? $signed(rd[CB-1:0]) : '0;
  assign ry = vc ? $signed(rd[2*CB-1:CB]) : '0;
  assign rz = vc ? $signed(rd[3*CB-1:2*CB]) : '0;

  // Shared multiplier, six products in turn.
  logic [2:0] mstep;
  logic signed [DW-1:0] m1, m2;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] n0, n1, n2;
  always_comb begin
    case (mstep)
      3'd0: begin m1 = uz; m2 = wy; end
      3'd1: begin m1 = uy; m2 = wz; end
      3'd2: begin m1 = ux; m2 = wz; end
      3'd3: begin m1 = uz; m2 = wx; end
      3'd4: begin m1 = uy; m2 = wx; end
      default: begin m1 = ux; m2 = wy; end
    endcase
  end

  // Normalization registers.
  localparam int GW = (NW > MB + 1) ? NW : MB + 1;
  logic [GW-1:0] g0, g1, g2, gmax;
  logic          s0, s1, s2;
  logic [1:0]    sqk;
  logic [tfn_pkg::SUM_BITS-1:0] ssum;
  logic [MB-1:0] sqop;
  logic [2*MB-1:0] sq;
  logic [tfn_pkg::ROOT_BITS-1:0] root, rreg;
  logic root_done, div_done;
  logic [tfn_pkg::QUO_BITS-1:0] quot;
  logic [1:0] dk;
  logic [MB-1:0] dmag;
  logic [tfn_pkg::DIVD_BITS-1:0] dividend;
  logic [15:0] q0, q1, q2;
  logic [15:0] qsat;
  logic        degen;

  assign gmax = (g0 > g1) ? ((g0 > g2) ? g0 : g2) : ((g1 > g2) ? g1 : g2);
  assign sqop = (sqk == 2'd0) ? g0[MB-1:0] : ((sqk == 2'd1) ? g1[MB-1:0] : g2[MB-1:0]);
  assign dmag = (dk == 2'd0) ? g0[MB-1:0] : ((dk == 2'd1) ? g1[MB-1:0] : g2[MB-1:0]);
  assign dividend = ({{(tfn_pkg::DIVD_BITS-MB){1'b0}}, dmag} << 24)
                    + tfn_pkg::DIVD_BITS'(rreg >> 1);
  assign qsat = (quot > tfn_pkg::QUO_BITS'(tfn_pkg::ONE_Q14)) ? 16'(tfn_pkg::ONE_Q14)
                : quot[15:0];

  function automatic logic [GW-1:0] mag_of(input logic signed [NW-1:0] v);
    logic [NW-1:0] a;
    a = v[NW-1] ? NW'(-v) : NW'(v);
    return GW'(a);
  endfunction

  always_comb begin
    root_ctl.start = (state == S_SQ) && (sqk == 2'd3);
    root_ctl.busy  = (state == S_ROOT);
    div_ctl.start  = (state == S_DIV);
    div_ctl.busy   = (state == S_DWAIT);
  end

  tfn_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(root_ctl.start),
    .radicand({ssum, 20'd0}), .done(root_done), .root(root)
  );

  tfn_div u_div (
    .clk(clk), .rst(rst), .start(div_ctl.start), .dividend(dividend),
    .divisor(rreg), .done(div_done), .quot(quot)
  );

  assign sq = sqop * sqop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_OUT the output register is refilled, so out_valid is set there.
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && !is_load) begin
            ca <= corner_a; cb_i <= corner_b; cc <= corner_c;
            va <= 32'(corner_a) < 32'(VERTEX_SLOTS);
            vb <= 32'(corner_b) < 32'(VERTEX_SLOTS);
            vc <= 32'(corner_c) < 32'(VERTEX_SLOTS);
            state <= S_RDA;
          end
        end
        S_RDA: begin vc <= va; state <= S_RDB; end
        S_RDB: begin
          ax <= rx; ay <= ry; az <= rz;
          vc <= vb; state <= S_RDC;
        end
        S_RDC: begin
          bx <= rx; by <= ry; bz <= rz;
          vc <= (32'(cc) < 32'(VERTEX_SLOTS)); state <= S_WC;
        end
        S_WC: begin
          ux <= DW'(bx) - DW'(ax); uy <= DW'(by) - DW'(ay); uz <= DW'(bz) - DW'(az);
          wx <= DW'(rx) - DW'(ax); wy <= DW'(ry) - DW'(ay); wz <= DW'(rz) - DW'(az);
          mstep <= 3'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= m1 * m2;
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1: n0 <= NW'(prod);
            3'd2: n0 <= n0 - NW'(prod);
            3'd3: n1 <= NW'(prod);
            3'd4: n1 <= n1 - NW'(prod);
            3'd5: n2 <= NW'(prod);
            3'd6: begin
              n2 <= n2 - NW'(prod);
              state <= S_NORM;
              g0 <= mag_of(n0); g1 <= mag_of(n1);
              g2 <= mag_of(n2 - NW'(prod));
              s0 <= n0[NW-1]; s1 <= n1[NW-1]; s2 <= (n2 - NW'(prod)) < 0;
            end
            default: ;
          endcase
        end
        S_NORM: begin
          if (gmax == '0) begin
            q0 <= '0; q1 <= '0; q2 <= '0;
            degen <= 1'b1;
            state <= S_OUT;
          end else if (gmax >= GW'(1 << MB)) begin
            g0 <= g0 >> 1; g1 <= g1 >> 1; g2 <= g2 >> 1;
          end else if (gmax < GW'(1 << (MB - 1))) begin
            g0 <= g0 << 1; g1 <= g1 << 1; g2 <= g2 << 1;
          end else begin
            sqk <= 2'd0; ssum <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (sqk != 2'd3) begin
            ssum <= ssum + tfn_pkg::SUM_BITS'(sq);
            sqk  <= sqk + 2'd1;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            rreg <= root; dk <= 2'd0; state <= S_DIV;
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            case (dk)
              2'd0: q0 <= s0 ? -qsat : qsat;
              2'd1: q1 <= s1 ? -qsat : qsat;
              default: q2 <= s2 ? -qsat : qsat;
            endcase
            if (dk == 2'd2) begin
              state <= S_OUT;
              degen <= 1'b0;
            end else begin
              dk <= dk + 2'd1; state <= S_DIV;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            norm_x <= q0; norm_y <= q1; norm_z <= q2;
            degenerate <= degen;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tfn_checker.sv -----
// Port-level checker for the triangle face normal block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module tfn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        opcode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] norm_x,
  input wire logic [15:0] norm_y,
  input wire logic [15:0] norm_z,
  input wire logic        degenerate
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(norm_x), "result dropped while stalled")
  `CHK_IMPLY(a_degen_zero, clk, rst, out_valid && degenerate, norm_x == 16'd0 && norm_y == 16'd0 && norm_z == 16'd0, "degenerate result not zero")
  `CHK_NEXT(a_tri_busy, clk, rst, in_valid && !in_stall && opcode == tfn_pkg::OP_TRI, in_stall || !in_valid || opcode == tfn_pkg::OP_LOAD, "second triangle taken at once")
endmodule
bind triangle_face_normal_top tfn_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
  .out_valid(out_valid), .out_stall(out_stall), .norm_x(norm_x), .norm_y(norm_y),
  .norm_z(norm_z), .degenerate(degenerate)
);
`default_nettype wire

// ----- sim/triangle_face_normal_top_test.sv -----
// Self-checking testbench for the triangle face normal block.
`timescale 1ns / 100ps
`default_nettype none
module triangle_face_normal_top_test;

  // Clock, reset and the ports of the block.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = tfn_pkg::OP_LOAD;
  logic [11:0] vertex_slot = '0;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [11:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic degenerate;

  triangle_face_normal_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .vertex_slot(vertex_slot),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One expected normal as the block should deliver it.
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic deg;
  } normal_t;

  // One row of directed stimulus. When has_exp is set, the expected normal is
  // typed into the row and must also agree with the predictor.
  typedef struct {
    logic op;
    logic [11:0] slot;
    logic signed [15:0] x, y, z;
    logic [11:0] ca, cb, cc;
    logic has_exp;
    normal_t exp;
  } row_t;

  // The testbench's own copy of the vertex store and the set of written slots.
  logic signed [15:0] vert_x [4096];
  logic signed [15:0] vert_y [4096];
  logic signed [15:0] vert_z [4096];
  bit written [4096];
  int unsigned written_list[$];

  normal_t pending_normals[$];
  int mismatches = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;        // No idling in the last part of the run.
  bit hold_rx = 1'b0;     // Long receiver hold-off requested.

  // Integer square root, floor, of a 64-bit value.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Predict the unit normal of triangle (a, b, c) from the store copy.
  function automatic normal_t face_normal(logic [11:0] ia, logic [11:0] ib,
                                          logic [11:0] ic);
    longint signed ax, ay, az, ux, uy, uz, vx, vy, vz;
    longint signed n [3];
    longint unsigned mag [3];
    longint unsigned m, s, r, q;
    logic signed [15:0] comp [3];
    normal_t res;
    ax = vert_x[ia]; ay = vert_y[ia]; az = vert_z[ia];
    ux = longint'(vert_x[ib]) - ax; uy = longint'(vert_y[ib]) - ay;
    uz = longint'(vert_z[ib]) - az;
    vx = longint'(vert_x[ic]) - ax; vy = longint'(vert_y[ic]) - ay;
    vz = longint'(vert_z[ic]) - az;
    n[0] = uz * vy - uy * vz;
    n[1] = ux * vz - uz * vx;
    n[2] = uy * vx - ux * vy;
    m = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (n[k] < 0) ? longint'(-n[k]) : longint'(n[k]);
      if (mag[k] > m) m = mag[k];
    end
    if (m == 0) begin
      res = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd0, deg: 1'b1};
      return res;
    end
    while (m >= (64'd1 << 20)) begin
      m >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    while (m < (64'd1 << 19)) begin
      m <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = root_floor(s << 20);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 24) + (r >> 1)) / r;
      if (q > tfn_pkg::ONE_Q14) q = tfn_pkg::ONE_Q14;
      comp[k] = (n[k] < 0) ? -q[15:0] : q[15:0];
    end
    res = '{nx: comp[0], ny: comp[1], nz: comp[2], deg: 1'b0};
    return res;
  endfunction

  // Record the effect of an accepted item on the store copy and expectations.
  function automatic void note_item(logic op, logic [11:0] slot,
                                    logic signed [15:0] x, logic signed [15:0] y,
                                    logic signed [15:0] z, logic [11:0] ca,
                                    logic [11:0] cb, logic [11:0] cc);
    if (op == tfn_pkg::OP_LOAD) begin
      vert_x[slot] = x; vert_y[slot] = y; vert_z[slot] = z;
      if (!written[slot]) written_list = {written_list, 32'(slot)};
      written[slot] = 1'b1;
    end else begin
      pending_normals = {pending_normals, face_normal(ca, cb, cc)};
    end
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_item(logic op, logic [11:0] slot, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z,
                           logic [11:0] ca, logic [11:0] cb, logic [11:0] cc);
    in_valid <= 1'b1;
    opcode <= op; vertex_slot <= slot;
    pos_x <= x; pos_y <= y; pos_z <= z;
    corner_a <= ca; corner_b <= cb; corner_c <= cc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    note_item(op, slot, x, y, z, ca, cb, cc);
  endtask

  // Random gaps between items, absent late in the run.
  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [11:0] pick_written();
    return 12'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  // Send a triangle of written corners, sometimes repeating a corner so
  // degenerate cases come up now and then.
  task automatic send_triangle();
    logic [11:0] a, b, c;
    a = pick_written(); b = pick_written(); c = pick_written();
    case ($urandom_range(0, 9))
      0: b = a;
      1: c = b;
      default: ;
    endcase
    send_item(tfn_pkg::OP_TRI, 12'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), a, b, c);
  endtask

  // Random load: mostly small coordinates so the cross product is modest,
  // sometimes full range; slots favor a small pool so triangles reuse them.
  task automatic send_load();
    logic [11:0] slot;
    logic signed [15:0] x, y, z;
    slot = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
    if ($urandom_range(0, 2) == 0) begin
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    end else begin
      x = 16'($signed($urandom_range(0, 2047)) - 1024);
      y = 16'($signed($urandom_range(0, 2047)) - 1024);
      z = 16'($signed($urandom_range(0, 2047)) - 1024);
    end
    send_item(tfn_pkg::OP_LOAD, slot, x, y, z, 12'($urandom), 12'($urandom),
              12'($urandom));
  endtask

  // Compare every delivered normal with the oldest expectation.
  always @(posedge clk) begin
    normal_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{nx: norm_x, ny: norm_y, nz: norm_z, deg: degenerate};
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected normal: %0d %0d %0d deg=%0b", norm_x, norm_y, norm_z,
                   degenerate);
      end else begin
        want = pending_normals.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Normal mismatch: expected %0d %0d %0d deg=%0b, got %0d %0d %0d deg=%0b",
                     want.nx, want.ny, want.nz, want.deg,
                     norm_x, norm_y, norm_z, degenerate);
        end
      end
    end
  end

  // Receiver stalls: random bursts, or a long hold-off on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Timeout: 1450 items at the slowest triangle time plus random stalls
  // on both sides and the long hold-off, taken several times over.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1_500_000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Directed rows. Slots 0..3, 5, 6 and 4095 get corner positions; expected
  // normals are typed in for the axis-aligned and degenerate triangles.
  localparam int DIR_ROWS = 20;
  row_t dir_rows [DIR_ROWS];

  initial begin
    normal_t chk;
    dir_rows[0]  = '{tfn_pkg::OP_LOAD, 12'd0, 16'sd0, 16'sd0, 16'sd0, '0, '0, '0,
                     1'b0, '0};
    dir_rows[1]  = '{tfn_pkg::OP_LOAD, 12'd1, 16'sd256, 16'sd0, 16'sd0, '0, '0, '0,
                     1'b0, '0};
    dir_rows[2]  = '{tfn_pkg::OP_LOAD, 12'd2, 16'sd0, 16'sd256, 16'sd0, '0, '0, '0,
                     1'b0, '0};
    dir_rows[3]  = '{tfn_pkg::OP_LOAD, 12'd3, 16'sd0, 16'sd0, 16'sd256, '0, '0, '0,
                     1'b0, '0};
    dir_rows[4]  = '{tfn_pkg::OP_LOAD, 12'd4095, -16'sd32768, -16'sd32768, -16'sd32768,
                     12'hFFF, 12'hFFF, 12'hFFF, 1'b0, '0};
    dir_rows[5]  = '{tfn_pkg::OP_LOAD, 12'd5, 16'sd32767, -16'sd32768, 16'sd32767,
                     '0, '0, '0, 1'b0, '0};
    dir_rows[6]  = '{tfn_pkg::OP_LOAD, 12'd6, -16'sd32768, 16'sd32767, -16'sd1,
                     '0, '0, '0, 1'b0, '0};
    // U = x, V = z: -(x cross z) = +y.
    dir_rows[7]  = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd0, 12'd1, 12'd3, 1'b1,
                     '{16'sd0, 16'sd16384, 16'sd0, 1'b0}};
    dir_rows[8]  = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd0, 12'd3, 12'd1, 1'b1,
                     '{16'sd0, -16'sd16384, 16'sd0, 1'b0}};
    // U = x, V = y: -(x cross y) = -z.
    dir_rows[9]  = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd0, 12'd1, 12'd2, 1'b1,
                     '{16'sd0, 16'sd0, -16'sd16384, 1'b0}};
    // U = y, V = z: -(y cross z) = -x.
    dir_rows[10] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd0, 12'd2, 12'd3, 1'b1,
                     '{-16'sd16384, 16'sd0, 16'sd0, 1'b0}};
    // Degenerate: repeated corners.
    dir_rows[11] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd1, 12'd1, 12'd1, 1'b1,
                     '{16'sd0, 16'sd0, 16'sd0, 1'b1}};
    dir_rows[12] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd4095, 12'd4095, 12'd2, 1'b1,
                     '{16'sd0, 16'sd0, 16'sd0, 1'b1}};
    // Extreme coordinates and ignored load fields, checked against the predictor only.
    dir_rows[13] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd4095, 12'd5, 12'd6, 1'b0, '0};
    dir_rows[14] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd5, 12'd6, 12'd4095, 1'b0, '0};
    dir_rows[15] = '{tfn_pkg::OP_TRI, 12'hFFF, 16'sd32767, 16'sd32767, 16'sd32767,
                     12'd1, 12'd2, 12'd3, 1'b0, '0};
    dir_rows[16] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd6, 12'd0, 12'd5, 1'b0, '0};
    // Overwrite a slot and use it again.
    dir_rows[17] = '{tfn_pkg::OP_LOAD, 12'd1, 16'sd1, -16'sd1, 16'sd1, '0, '0, '0,
                     1'b0, '0};
    dir_rows[18] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd1, 12'd2, 12'd3, 1'b0, '0};
    dir_rows[19] = '{tfn_pkg::OP_TRI, '0, '0, '0, '0, 12'd3, 12'd0, 12'd1, 1'b0, '0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].has_exp) begin
        chk = face_normal(dir_rows[i].ca, dir_rows[i].cb, dir_rows[i].cc);
        if (chk !== dir_rows[i].exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Table row %0d disagrees with predictor", i);
        end
      end
      send_item(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].x, dir_rows[i].y,
                dir_rows[i].z, dir_rows[i].ca, dir_rows[i].cb, dir_rows[i].cc);
      sender_gap();
    end

    // Random part: loads and triangles over written slots.
    for (int i = 0; i < 1430; i++) begin
      if (i == 300) begin
        // Long receiver hold-off while items keep coming.
        hold_rx = 1'b1;
      end
      if (i == 700) begin
        // Sender waits until every expected normal has arrived.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_normals.size() != 0) @(posedge clk);
      end
      if (i == 1200) calm = 1'b1;
      if ($urandom_range(0, 9) < 4) send_load();
      else send_triangle();
      sender_gap();
    end
    in_valid <= 1'b0;

    while (pending_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
